// ===== design/ils_pkg.sv =====
package ils_pkg;

   localparam int CAPACITY   = 64;
   localparam int DATA_WIDTH = 32;
   localparam int ADDR_W     = $clog2(CAPACITY);
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   localparam logic [1:0] CMD_GET    = 2'd0;
   localparam logic [1:0] CMD_FIND   = 2'd1;
   localparam logic [1:0] CMD_ERASE  = 2'd2;
   localparam logic [1:0] CMD_INSERT = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_NOT_FOUND = 2'd3;

endpackage

// ===== design/ils_ram.sv =====
module ils_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/indexed_list_store_unit.sv =====
// Ordered list of up to CAPACITY values in one single-port-read, single-port-write RAM.
// An item is taken when start is high and busy is low; its result appears on the rsp_
// ports for one cycle with rsp_valid, the cycle after the work ends, and must be taken
// then. Out-of-range commands, a full insert, a find on an empty list, an erase of the
// last entry and an insert at index count answer from S_IDLE. Get reads the RAM and
// answers in S_GET. Find reads one stored entry per cycle from index 0 until a match or
// the last entry. Erase at p moves the entries above p down and insert at p moves those
// from p up, one entry per cycle via the RAM's ports; S_INS_LAST then writes the value.
module indexed_list_store_unit
   import ils_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_cmd,
   input  logic [CNT_W-1:0]      req_position,
   input  logic [DATA_WIDTH-1:0] req_item_value,
   output logic                  rsp_valid,
   output logic [DATA_WIDTH-1:0] rsp_read_value,
   output logic [ADDR_W-1:0]     rsp_found_index,
   output logic [1:0]            rsp_status,
   output logic [CNT_W-1:0]      rsp_count,
   output logic                  rsp_is_empty
);

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_GET      = 3'd1;
   localparam logic [2:0] S_FIND     = 3'd2;
   localparam logic [2:0] S_ERASE    = 3'd3;
   localparam logic [2:0] S_INSERT   = 3'd4;
   localparam logic [2:0] S_INS_LAST = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [CNT_W-1:0]      pos_ff, pos_in;
   logic [DATA_WIDTH-1:0] val_ff, val_in;
   logic [ADDR_W-1:0]     idx_ff, idx_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_read_ff, rsp_read_in;
   logic [ADDR_W-1:0]     rsp_fidx_ff, rsp_fidx_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_empty_ff;

   logic                  wr_en, rd_en;
   logic [ADDR_W-1:0]     wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data, rd_data;

   logic [CNT_W-1:0]      cnt_m1;
   logic                  accept;

   ils_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign cnt_m1 = count_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = 1'b0;
      rsp_read_in   = '0;
      rsp_fidx_in   = '0;
      rsp_status_in = ST_OK;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in = req_position;
               val_in = req_item_value;
               case (req_cmd)
                  CMD_GET: begin
                     if (req_position < count_ff) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_position[ADDR_W-1:0];
                        state_in = S_GET;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_INDEX;
                     end
                  end
                  CMD_FIND: begin
                     if (count_ff != '0) begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = S_FIND;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  CMD_ERASE: begin
                     if (req_position >= count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_INDEX;
                     end else if (req_position == cnt_m1) begin
                        count_in     = cnt_m1;
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = req_position[ADDR_W-1:0] + ADDR_W'(1);
                        idx_in   = req_position[ADDR_W-1:0];
                        state_in = S_ERASE;
                     end
                  end
                  default: begin
                     if (req_position > count_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_BAD_INDEX;
                     end else if (count_ff >= CNT_W'(CAPACITY)) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_FULL;
                     end else if (req_position == count_ff) begin
                        wr_en        = 1'b1;
                        wr_addr      = req_position[ADDR_W-1:0];
                        wr_data      = req_item_value;
                        count_in     = count_ff + CNT_W'(1);
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_m1[ADDR_W-1:0];
                        idx_in   = count_ff[ADDR_W-1:0];
                        state_in = S_INSERT;
                     end
                  end
               endcase
            end
         end
         S_GET: begin
            rsp_valid_in = 1'b1;
            rsp_read_in  = rd_data;
            state_in     = S_IDLE;
         end
         S_FIND: begin
            if (rd_data == val_ff) begin
               rsp_valid_in = 1'b1;
               rsp_fidx_in  = idx_ff;
               state_in     = S_IDLE;
            end else if (CNT_W'(idx_ff) + CNT_W'(1) == count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_NOT_FOUND;
               state_in      = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + ADDR_W'(1);
               idx_in  = idx_ff + ADDR_W'(1);
            end
         end
         S_ERASE: begin
            wr_en = 1'b1;
            if (CNT_W'(idx_ff) + CNT_W'(2) == count_ff) begin
               count_in     = cnt_m1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff + ADDR_W'(2);
               idx_in  = idx_ff + ADDR_W'(1);
            end
         end
         S_INSERT: begin
            wr_en = 1'b1;
            if (idx_ff - ADDR_W'(1) == pos_ff[ADDR_W-1:0]) begin
               state_in = S_INS_LAST;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_ff - ADDR_W'(2);
               idx_in  = idx_ff - ADDR_W'(1);
            end
         end
         S_INS_LAST: begin
            wr_en        = 1'b1;
            wr_addr      = pos_ff[ADDR_W-1:0];
            wr_data      = val_ff;
            count_in     = count_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      val_ff        <= val_in;
      idx_ff        <= idx_in;
      rsp_read_ff   <= rsp_read_in;
      rsp_fidx_ff   <= rsp_fidx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= count_in;
      rsp_empty_ff  <= (count_in == '0);
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_ff;
   assign rsp_found_index = rsp_fidx_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule
